>>> rtl/tss_pkg.sv
// shared types, codes and reset values of the time sync supervisor
`default_nettype none

package tss_pkg;

    localparam int unsigned TimeWidth = 32;
    localparam int unsigned CountWidth = 8;
    localparam int unsigned InDataWidth = 40;
    localparam int unsigned OutDataWidth = 24;

    localparam logic [TimeWidth-1:0] UpdatePeriodReset = 32'd1000;
    localparam logic [TimeWidth-1:0] SyncPeriodReset = 32'd3600000;
    localparam logic [TimeWidth-1:0] NtpWarnReset = 32'd60000;
    localparam logic [CountWidth-1:0] MaxFailuresReset = 8'd3;
    localparam logic [CountWidth-1:0] CountMax = 8'hFF;

    typedef enum logic [1:0] {
        MODE_RTC    = 2'd0,
        MODE_WAIT   = 2'd1,
        MODE_ACTIVE = 2'd2,
        MODE_FAULT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_USER   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_SPARE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        FLT_NONE   = 2'd0,
        FLT_NO_DEV = 2'd1,
        FLT_READ   = 2'd2,
        FLT_WRITE  = 2'd3
    } fault_t;

    typedef enum logic [1:0] {
        USR_NONE   = 2'd0,
        USR_OK     = 2'd1,
        USR_ACTIVE = 2'd2,
        USR_FAILED = 2'd3
    } user_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_DEV   = 2'd1,
        ST_LOST_PWR = 2'd2,
        ST_INIT_BAD = 2'd3
    } start_t;

    typedef enum logic [1:0] {
        REG_UPDATE_PERIOD = 2'd0,
        REG_SYNC_PERIOD   = 2'd1,
        REG_NTP_WARN      = 2'd2,
        REG_MAX_FAILURES  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [TimeWidth-1:0]  update_period_ms;
        logic [TimeWidth-1:0]  sync_period_ms;
        logic [TimeWidth-1:0]  ntp_warn_ms;
        logic [CountWidth-1:0] max_failures;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           operation;
        logic [TimeWidth-1:0] now_ms;
        logic                 wifi_up;
        logic                 ntp_done;
        logic                 read_ok;
        logic                 write_ok;
        logic [1:0]           start_status;
    } item_t;

    typedef struct packed {
        logic [1:0]            sync_state;
        logic [1:0]            action;
        logic [1:0]            fault_code;
        logic                  power_lost;
        logic [1:0]            user_result;
        logic                  ntp_warning;
        logic [CountWidth-1:0] failure_count;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/tss_cfg_regs.sv
// configuration register file of the time sync supervisor
`default_nettype none

module tss_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [1:0]                    wr_index,
    input  wire logic [tss_pkg::TimeWidth-1:0] wr_data,
    output tss_pkg::cfg_t                      cfg
);

    tss_pkg::cfg_t cfg_reg;
    tss_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (tss_pkg::reg_index_t'(wr_index))
                tss_pkg::REG_UPDATE_PERIOD: cfg_next.update_period_ms = wr_data;
                tss_pkg::REG_SYNC_PERIOD:   cfg_next.sync_period_ms = wr_data;
                tss_pkg::REG_NTP_WARN:      cfg_next.ntp_warn_ms = wr_data;
                tss_pkg::REG_MAX_FAILURES:
                    cfg_next.max_failures = wr_data[tss_pkg::CountWidth-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.update_period_ms <= tss_pkg::UpdatePeriodReset;
            cfg_reg.sync_period_ms <= tss_pkg::SyncPeriodReset;
            cfg_reg.ntp_warn_ms <= tss_pkg::NtpWarnReset;
            cfg_reg.max_failures <= tss_pkg::MaxFailuresReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/tss_core.sv
// supervisor state registers and the per-item update logic
`default_nettype none

module tss_core (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    step_en,
    input  wire tss_pkg::item_t item,
    input  wire tss_pkg::cfg_t  cfg,
    output tss_pkg::result_t result
);

    tss_pkg::mode_t                    mode_reg, mode_next;
    logic [tss_pkg::TimeWidth-1:0]     last_update_reg, last_update_next;
    logic [tss_pkg::TimeWidth-1:0]     last_sync_reg, last_sync_next;
    logic [tss_pkg::TimeWidth-1:0]     wait_start_reg, wait_start_next;
    logic [tss_pkg::CountWidth-1:0]    fail_count_reg, fail_count_next;
    logic                              force_reg, force_next;
    logic                              lost_reg, lost_next;
    logic [1:0]                        fault_reg, fault_next;

    logic [tss_pkg::TimeWidth-1:0]     since_update;
    logic [tss_pkg::TimeWidth-1:0]     since_sync;
    logic [tss_pkg::TimeWidth-1:0]     since_wait;
    logic [tss_pkg::CountWidth-1:0]    fail_inc;
    logic                              fail_hit;
    logic                              sync_due;
    logic                              update_go;
    logic                              read_try;
    logic [1:0]                        action;
    logic [1:0]                        user;
    logic                              warn;

    assign since_update = item.now_ms - last_update_reg;
    assign since_sync = item.now_ms - last_sync_reg;
    assign since_wait = item.now_ms - wait_start_reg;
    assign update_go = since_update >= cfg.update_period_ms;
    assign sync_due = force_reg || (since_sync >= cfg.sync_period_ms);
    assign read_try = !lost_reg && sync_due;
    // failure counter saturates
    assign fail_inc = (fail_count_reg == tss_pkg::CountMax) ? fail_count_reg
                                                          : fail_count_reg + 8'd1;
    assign fail_hit = fail_inc >= cfg.max_failures;

    always_comb begin
        mode_next = mode_reg;
        last_update_next = last_update_reg;
        last_sync_next = last_sync_reg;
        wait_start_next = wait_start_reg;
        fail_count_next = fail_count_reg;
        force_next = force_reg;
        lost_next = lost_reg;
        fault_next = fault_reg;
        action = tss_pkg::ACT_NONE;
        user = tss_pkg::USR_NONE;
        warn = 1'b0;

        case (tss_pkg::op_t'(item.operation))
            tss_pkg::OP_START: begin
                last_update_next = item.now_ms - cfg.update_period_ms;
                case (tss_pkg::start_t'(item.start_status))
                    tss_pkg::ST_OK: begin
                        action = tss_pkg::ACT_READ;
                        force_next = 1'b0;
                        last_sync_next = item.now_ms;
                        fail_count_next = '0;
                    end
                    tss_pkg::ST_NO_DEV: begin
                        if (mode_reg != tss_pkg::MODE_FAULT) begin
                            mode_next = tss_pkg::MODE_FAULT;
                            fault_next = tss_pkg::FLT_NO_DEV;
                        end
                    end
                    tss_pkg::ST_LOST_PWR: begin
                        lost_next = 1'b1;
                    end
                    default: begin
                        action = tss_pkg::ACT_READ;
                        if (mode_reg != tss_pkg::MODE_FAULT) begin
                            mode_next = tss_pkg::MODE_FAULT;
                            fault_next = tss_pkg::FLT_READ;
                        end
                    end
                endcase
            end
            tss_pkg::OP_UPDATE: begin
                if (update_go) begin
                    last_update_next = item.now_ms;
                    case (mode_reg)
                        tss_pkg::MODE_RTC: begin
                            if (item.wifi_up) begin
                                mode_next = tss_pkg::MODE_WAIT;
                                wait_start_next = item.now_ms;
                            end else if (read_try) begin
                                action = tss_pkg::ACT_READ;
                                if (item.read_ok) begin
                                    force_next = 1'b0;
                                    last_sync_next = item.now_ms;
                                    fail_count_next = '0;
                                end else begin
                                    fail_count_next = fail_inc;
                                    if (fail_hit) begin
                                        mode_next = tss_pkg::MODE_FAULT;
                                        fault_next = tss_pkg::FLT_READ;
                                    end
                                end
                            end
                        end
                        tss_pkg::MODE_WAIT: begin
                            if (!item.wifi_up) begin
                                mode_next = tss_pkg::MODE_RTC;
                                fail_count_next = '0;
                            end else if (read_try && !item.read_ok) begin
                                // failed read ends this update
                                action = tss_pkg::ACT_READ;
                                fail_count_next = fail_inc;
                                if (fail_hit) begin
                                    mode_next = tss_pkg::MODE_FAULT;
                                    fault_next = tss_pkg::FLT_READ;
                                end
                            end else begin
                                if (read_try) begin
                                    action = tss_pkg::ACT_READ;
                                    force_next = 1'b0;
                                    last_sync_next = item.now_ms;
                                    fail_count_next = '0;
                                end
                                if (item.ntp_done) begin
                                    mode_next = tss_pkg::MODE_ACTIVE;
                                    fail_count_next = '0;
                                    force_next = 1'b1;
                                end else if (since_wait >= cfg.ntp_warn_ms) begin
                                    warn = 1'b1;
                                    wait_start_next = item.now_ms;
                                end
                            end
                        end
                        tss_pkg::MODE_ACTIVE: begin
                            if (!item.wifi_up) begin
                                mode_next = tss_pkg::MODE_RTC;
                                fail_count_next = '0;
                            end else if (sync_due) begin
                                action = tss_pkg::ACT_WRITE;
                                if (item.write_ok) begin
                                    force_next = 1'b0;
                                    last_sync_next = item.now_ms;
                                    fail_count_next = '0;
                                    lost_next = 1'b0;
                                end else begin
                                    fail_count_next = fail_inc;
                                    if (fail_hit) begin
                                        mode_next = tss_pkg::MODE_FAULT;
                                        fault_next = tss_pkg::FLT_WRITE;
                                    end
                                end
                            end
                        end
                        default: begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            end
            tss_pkg::OP_USER: begin
                if (mode_reg == tss_pkg::MODE_ACTIVE) begin
                    user = tss_pkg::USR_ACTIVE;
                end else begin
                    action = tss_pkg::ACT_WRITE;
                    if (item.write_ok) begin
                        force_next = 1'b1;
                        user = tss_pkg::USR_OK;
                    end else begin
                        user = tss_pkg::USR_FAILED;
                    end
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= tss_pkg::MODE_RTC;
            last_update_reg <= '0;
            last_sync_reg <= '0;
            wait_start_reg <= '0;
            fail_count_reg <= '0;
            force_reg <= 1'b0;
            lost_reg <= 1'b0;
            fault_reg <= tss_pkg::FLT_NONE;
        end else if (step_en) begin
            mode_reg <= mode_next;
            last_update_reg <= last_update_next;
            last_sync_reg <= last_sync_next;
            wait_start_reg <= wait_start_next;
            fail_count_reg <= fail_count_next;
            force_reg <= force_next;
            lost_reg <= lost_next;
            fault_reg <= fault_next;
        end
    end

    always_comb begin
        result.sync_state = mode_next;
        result.action = action;
        result.fault_code = fault_next;
        result.power_lost = lost_next;
        result.user_result = user;
        result.ntp_warning = warn;
        result.failure_count = fail_count_next;
    end

endmodule

`default_nettype wire

>>> rtl/time_sync_supervisor.sv
// Time sync supervisor: decides which source keeps time and which sync to make.
//
// Input channel s_*: one transfer per item; s_tuser carries the operation
// (start report, periodic update, user request), s_tdata the tick count, the
// link and network status, the sync outcomes and the start status.
// Result channel m_*: exactly one result transfer per input transfer, in order.
// Configuration channel cfg_*: register index and data, always ready; the user
// must write it only while no item is in flight, which the block does not enforce.
// Path: an item taken into the input register is stepped through the core and
// its result is registered in the result register, which drives m_*.
// Throughput: one item per cycle while m_tready keeps up; the whole state update
// is a combinational step in the core between the input and result registers.
// Stalls: when m_tready is low the result register holds, the input register
// fills, and s_tready then drops until the result is taken.
// Reset (aresetn low, synchronous): both registers empty, supervisor back to
// rtc only with all timers, counters and flags cleared, configuration at its
// default values.
`default_nettype none

module time_sync_supervisor (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // now_ms[31:0], wifi_up[32], ntp_done[33], read_ok[34], write_ok[35],
    // start_status[37:36], zero pad[39:38]
    input  wire logic [tss_pkg::InDataWidth-1:0]  s_tdata,
    // operation[1:0]
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // sync_state[1:0], action[3:2], fault_code[5:4], power_lost[6],
    // user_result[8:7], ntp_warning[9], failure_count[17:10], zero pad[23:18]
    output logic [tss_pkg::OutDataWidth-1:0]      m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [tss_pkg::TimeWidth-1:0]    cfg_data
);

    tss_pkg::cfg_t    cfg;
    tss_pkg::item_t   item_reg, item_next;
    logic             in_vld_reg, in_vld_next;
    tss_pkg::result_t res;
    tss_pkg::result_t res_reg;
    logic             out_vld_reg, out_vld_next;
    logic             out_free;
    logic             step_en;
    logic             s_xfer;

    assign cfg_ready = 1'b1;

    tss_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign out_free = !out_vld_reg || m_tready;
    assign step_en = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign s_xfer = s_tvalid && s_tready;

    always_comb begin
        item_next = item_reg;
        if (s_xfer) begin
            item_next.operation = s_tuser;
            item_next.now_ms = s_tdata[31:0];
            item_next.wifi_up = s_tdata[32];
            item_next.ntp_done = s_tdata[33];
            item_next.read_ok = s_tdata[34];
            item_next.write_ok = s_tdata[35];
            item_next.start_status = s_tdata[37:36];
        end
        in_vld_next = s_xfer || (in_vld_reg && !step_en);
        out_vld_next = step_en || (out_vld_reg && !m_tready);
    end

    tss_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        if (step_en) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata = {6'd0, res_reg.failure_count, res_reg.ntp_warning,
                      res_reg.user_result, res_reg.power_lost, res_reg.fault_code,
                      res_reg.action, res_reg.sync_state};

endmodule

`default_nettype wire

>>> rtl/tss_checker.sv
// port-level checks of the time sync supervisor, bound to the top level
`default_nettype none

module tss_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [tss_pkg::OutDataWidth-1:0] m_tdata
);

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // fault state always carries a fault code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == tss_pkg::MODE_FAULT
        |-> m_tdata[5:4] != tss_pkg::FLT_NONE)
        else $error("fault state without fault code");

    // refused user request only in network active, with no action
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8:7] == tss_pkg::USR_ACTIVE
        |-> m_tdata[3:2] == tss_pkg::ACT_NONE
            && m_tdata[1:0] == tss_pkg::MODE_ACTIVE)
        else $error("user refusal outside network active");

    // warning pulse only while waiting for network time
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[1:0] == tss_pkg::MODE_WAIT
            && m_tdata[8:7] == tss_pkg::USR_NONE)
        else $error("network wait warning outside wait state");

endmodule

bind time_sync_supervisor tss_checker u_tss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/time_sync_supervisor_tb.sv
// self-checking testbench for the time sync supervisor: directed table, then random phases
`timescale 1ns / 1ps

module time_sync_supervisor_tb;

    localparam int QuietLimit = 400;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // now_ms[31:0], wifi_up[32], ntp_done[33], read_ok[34], write_ok[35],
    // start_status[37:36], zero pad[39:38]
    logic [tss_pkg::InDataWidth-1:0] s_tdata = '0;
    // operation[1:0]
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // sync_state[1:0], action[3:2], fault_code[5:4], power_lost[6],
    // user_result[8:7], ntp_warning[9], failure_count[17:10], zero pad[23:18]
    logic [tss_pkg::OutDataWidth-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [tss_pkg::TimeWidth-1:0] cfg_data = '0;

    time_sync_supervisor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // shadow configuration
    logic [tss_pkg::TimeWidth-1:0]  c_update = tss_pkg::UpdatePeriodReset;
    logic [tss_pkg::TimeWidth-1:0]  c_sync   = tss_pkg::SyncPeriodReset;
    logic [tss_pkg::TimeWidth-1:0]  c_warn   = tss_pkg::NtpWarnReset;
    logic [tss_pkg::CountWidth-1:0] c_maxf   = tss_pkg::MaxFailuresReset;

    // shadow supervisor state
    tss_pkg::mode_t                 sv_mode = tss_pkg::MODE_RTC;
    logic [tss_pkg::TimeWidth-1:0]  t_last_update = '0;
    logic [tss_pkg::TimeWidth-1:0]  t_last_sync = '0;
    logic [tss_pkg::TimeWidth-1:0]  t_wait_start = '0;
    logic [tss_pkg::CountWidth-1:0] n_fail = '0;
    bit                             f_force = 1'b0;
    bit                             f_lost = 1'b0;
    tss_pkg::fault_t                f_code = tss_pkg::FLT_NONE;

    tss_pkg::result_t status_queue[$];

    typedef struct {
        tss_pkg::item_t   it;
        bit               typed;
        tss_pkg::result_t res;
    } row_t;
    row_t plan[$];

    // stimulus generator state
    logic [tss_pkg::TimeWidth-1:0] tick = '0;
    bit link_up = 1'b0;
    bit ntp_up = 1'b0;
    bit calm = 1'b0;

    int n_items = 0;
    int n_results = 0;
    int n_mismatch = 0;
    int n_cfg = 0;
    int n_settings = 0;
    int n_warnings = 0;
    int state_hits[4] = '{0, 0, 0, 0};
    int quiet = 0;

    tss_pkg::result_t got;
    tss_pkg::result_t want;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // ------------------------------------------------------------------
    // predictor

    function automatic void enter_fault(tss_pkg::fault_t code);
        if (sv_mode != tss_pkg::MODE_FAULT) begin
            f_code = code;
            sv_mode = tss_pkg::MODE_FAULT;
        end
    endfunction

    function automatic void change_mode(tss_pkg::mode_t nxt,
                                        logic [tss_pkg::TimeWidth-1:0] now);
        if (sv_mode != nxt) begin
            sv_mode = nxt;
            case (nxt)
                tss_pkg::MODE_RTC: n_fail = '0;
                tss_pkg::MODE_WAIT: t_wait_start = now;
                tss_pkg::MODE_ACTIVE: begin
                    n_fail = '0;
                    f_force = 1'b1;
                end
                default: ;
            endcase
        end
    endfunction

    function automatic bit sync_due(logic [tss_pkg::TimeWidth-1:0] now);
        logic [tss_pkg::TimeWidth-1:0] since_sync;
        since_sync = now - t_last_sync;
        return f_force || (since_sync >= c_sync);
    endfunction

    function automatic void sync_good(logic [tss_pkg::TimeWidth-1:0] now);
        f_force = 1'b0;
        t_last_sync = now;
        n_fail = '0;
    endfunction

    function automatic void sync_bad(tss_pkg::fault_t code);
        if (n_fail != tss_pkg::CountMax)
            n_fail = n_fail + 1'b1;
        if (n_fail >= c_maxf)
            enter_fault(code);
    endfunction

    function automatic tss_pkg::result_t step_supervisor(tss_pkg::item_t it);
        tss_pkg::result_t r;
        logic [tss_pkg::TimeWidth-1:0] now;
        logic [tss_pkg::TimeWidth-1:0] since;
        logic [tss_pkg::TimeWidth-1:0] waited;
        bit failed;
        r = '0;
        now = it.now_ms;
        failed = 1'b0;
        case (it.operation)
            tss_pkg::OP_START: begin
                t_last_update = now - c_update;
                case (it.start_status)
                    tss_pkg::ST_OK: begin
                        r.action = tss_pkg::ACT_READ;
                        sync_good(now);
                    end
                    tss_pkg::ST_NO_DEV: enter_fault(tss_pkg::FLT_NO_DEV);
                    tss_pkg::ST_LOST_PWR: f_lost = 1'b1;
                    default: begin
                        r.action = tss_pkg::ACT_READ;
                        enter_fault(tss_pkg::FLT_READ);
                    end
                endcase
            end
            tss_pkg::OP_UPDATE: begin
                since = now - t_last_update;
                if (since >= c_update) begin
                    t_last_update = now;
                    case (sv_mode)
                        tss_pkg::MODE_RTC: begin
                            if (it.wifi_up) begin
                                change_mode(tss_pkg::MODE_WAIT, now);
                            end else if (!f_lost && sync_due(now)) begin
                                r.action = tss_pkg::ACT_READ;
                                if (it.read_ok) sync_good(now);
                                else sync_bad(tss_pkg::FLT_READ);
                            end
                        end
                        tss_pkg::MODE_WAIT: begin
                            if (!it.wifi_up) begin
                                change_mode(tss_pkg::MODE_RTC, now);
                            end else begin
                                if (!f_lost && sync_due(now)) begin
                                    r.action = tss_pkg::ACT_READ;
                                    if (it.read_ok) begin
                                        sync_good(now);
                                    end else begin
                                        sync_bad(tss_pkg::FLT_READ);
                                        failed = 1'b1;
                                    end
                                end
                                // a failed read holds off the move to network time
                                if (!failed) begin
                                    waited = now - t_wait_start;
                                    if (it.ntp_done) begin
                                        change_mode(tss_pkg::MODE_ACTIVE, now);
                                    end else if (waited >= c_warn) begin
                                        r.ntp_warning = 1'b1;
                                        t_wait_start = now;
                                    end
                                end
                            end
                        end
                        tss_pkg::MODE_ACTIVE: begin
                            if (!it.wifi_up) begin
                                change_mode(tss_pkg::MODE_RTC, now);
                            end else if (sync_due(now)) begin
                                r.action = tss_pkg::ACT_WRITE;
                                if (it.write_ok) begin
                                    sync_good(now);
                                    f_lost = 1'b0;
                                end else begin
                                    sync_bad(tss_pkg::FLT_WRITE);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            tss_pkg::OP_USER: begin
                if (sv_mode == tss_pkg::MODE_ACTIVE) begin
                    r.user_result = tss_pkg::USR_ACTIVE;
                end else begin
                    r.action = tss_pkg::ACT_WRITE;
                    if (it.write_ok) begin
                        f_force = 1'b1;
                        r.user_result = tss_pkg::USR_OK;
                    end else begin
                        r.user_result = tss_pkg::USR_FAILED;
                    end
                end
            end
            default: ;
        endcase
        r.sync_state = sv_mode;
        r.fault_code = f_code;
        r.power_lost = f_lost;
        r.failure_count = n_fail;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus

    function automatic tss_pkg::item_t make_item(bit faulting);
        tss_pkg::item_t it;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 68) it.operation = tss_pkg::OP_UPDATE;
        else if (roll < 80) it.operation = tss_pkg::OP_USER;
        else if (roll < 92) it.operation = tss_pkg::OP_START;
        else it.operation = tss_pkg::OP_UNUSED;
        // mostly just past the update period, with sync and warning boundaries and jumps
        roll = $urandom_range(0, 99);
        if (roll < 60) tick = tick + c_update + $urandom_range(0, 3);
        else if (roll < 75) tick = tick + $urandom_range(0, c_update);
        else if (roll < 85) tick = tick + c_sync;
        else if (roll < 93) tick = tick + c_warn;
        else tick = $urandom;
        it.now_ms = tick;
        if ($urandom_range(0, 7) == 0) link_up = ~link_up;
        if (!link_up) ntp_up = 1'b0;
        else if ($urandom_range(0, 3) == 0) ntp_up = 1'b1;
        it.wifi_up = link_up;
        it.ntp_done = ntp_up;
        if ($urandom_range(0, 19) == 0) begin
            it.wifi_up = 1'($urandom_range(0, 1));
            it.ntp_done = 1'($urandom_range(0, 1));
        end
        it.read_ok = ($urandom_range(0, 4) != 0);
        it.write_ok = ($urandom_range(0, 4) != 0);
        if (faulting) begin
            it.start_status = tss_pkg::start_t'($urandom_range(0, 3));
        end else begin
            it.start_status = ($urandom_range(0, 3) == 0) ? tss_pkg::ST_LOST_PWR
                                                          : tss_pkg::ST_OK;
            // the fault is terminal, so keep clear of it until the last phase
            if (int'(n_fail) + 1 >= int'(c_maxf)) begin
                it.read_ok = 1'b1;
                it.write_ok = 1'b1;
            end
        end
        return it;
    endfunction

    task automatic add_row(tss_pkg::op_t op, logic [tss_pkg::TimeWidth-1:0] now, bit wifi,
                           bit ntp, bit rok, bit wok, tss_pkg::start_t st, bit typed,
                           tss_pkg::mode_t m, tss_pkg::action_t a, tss_pkg::user_t u,
                           bit lost, bit warn, logic [tss_pkg::CountWidth-1:0] cnt);
        row_t row;
        row.it.operation = op;
        row.it.now_ms = now;
        row.it.wifi_up = wifi;
        row.it.ntp_done = ntp;
        row.it.read_ok = rok;
        row.it.write_ok = wok;
        row.it.start_status = st;
        row.typed = typed;
        row.res = '0;
        row.res.sync_state = m;
        row.res.action = a;
        row.res.fault_code = tss_pkg::FLT_NONE;
        row.res.power_lost = lost;
        row.res.user_result = u;
        row.res.ntp_warning = warn;
        row.res.failure_count = cnt;
        plan.push_back(row);
    endtask

    task automatic send(tss_pkg::item_t it, bit typed, tss_pkg::result_t typed_res);
        tss_pkg::result_t guess;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= it.operation;
        s_tdata <= {2'b00, it.start_status, it.write_ok, it.read_ok, it.ntp_done,
                    it.wifi_up, it.now_ms};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        guess = step_supervisor(it);
        status_queue.push_back(typed ? typed_res : guess);
        n_items++;
        state_hits[guess.sync_state]++;
        n_warnings += guess.ntp_warning;
    endtask

    task automatic pause(int unsigned cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // hold the sender until every result is in, then let the pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (status_queue.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(tss_pkg::reg_index_t idx, logic [tss_pkg::TimeWidth-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) @(posedge aclk);
        case (idx)
            tss_pkg::REG_UPDATE_PERIOD: c_update = val;
            tss_pkg::REG_SYNC_PERIOD: c_sync = val;
            tss_pkg::REG_NTP_WARN: c_warn = val;
            default: c_maxf = val[tss_pkg::CountWidth-1:0];
        endcase
        n_cfg++;
    endtask

    task automatic apply_settings(logic [tss_pkg::TimeWidth-1:0] up,
                                  logic [tss_pkg::TimeWidth-1:0] sy,
                                  logic [tss_pkg::TimeWidth-1:0] wn,
                                  logic [tss_pkg::CountWidth-1:0] mf);
        write_reg(tss_pkg::REG_UPDATE_PERIOD, up);
        write_reg(tss_pkg::REG_SYNC_PERIOD, sy);
        write_reg(tss_pkg::REG_NTP_WARN, wn);
        write_reg(tss_pkg::REG_MAX_FAILURES,
                  {{(tss_pkg::TimeWidth-tss_pkg::CountWidth){1'b0}}, mf});
        @(negedge aclk);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // result side

    initial begin
        int unsigned hold;
        hold = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (calm) begin
                m_tready <= 1'b1;
            end else if (hold != 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 11);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            got.sync_state = m_tdata[1:0];
            got.action = m_tdata[3:2];
            got.fault_code = m_tdata[5:4];
            got.power_lost = m_tdata[6];
            got.user_result = m_tdata[8:7];
            got.ntp_warning = m_tdata[9];
            got.failure_count = m_tdata[17:10];
            if (status_queue.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("result %0d arrived with nothing outstanding", n_results);
            end else begin
                want = status_queue.pop_front();
                if (got !== want || m_tdata[23:18] !== '0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("result %0d expected: state %0d act %0d fault %0d lost %0d %s",
                                 n_results, want.sync_state, want.action, want.fault_code,
                                 want.power_lost, "");
                        $display("    user %0d warn %0d count %0d", want.user_result,
                                 want.ntp_warning, want.failure_count);
                        $display("result %0d actual:   state %0d act %0d fault %0d lost %0d",
                                 n_results, got.sync_state, got.action, got.fault_code,
                                 got.power_lost);
                        $display("    user %0d warn %0d count %0d pad %0h", got.user_result,
                                 got.ntp_warning, got.failure_count, m_tdata[23:18]);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QuietLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence

    initial begin
        int p;
        int k;
        int count;
        row_t row;
        tss_pkg::item_t it;

        // defaults after reset: update 1000, sync 3600000, warn 60000, three failures
        add_row(tss_pkg::OP_UPDATE, 32'd0, 0, 0, 0, 0, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_RTC, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 0, 0, 0);
        add_row(tss_pkg::OP_UNUSED, 32'hFFFF_FFFF, 1, 1, 1, 1, tss_pkg::ST_INIT_BAD, 1,
                tss_pkg::MODE_RTC, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 0, 0, 0);
        add_row(tss_pkg::OP_UPDATE, 32'd1000, 0, 0, 0, 0, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_RTC, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 0, 0, 0);
        add_row(tss_pkg::OP_START, 32'd5000, 0, 0, 0, 0, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_RTC, tss_pkg::ACT_READ, tss_pkg::USR_NONE, 0, 0, 0);
        add_row(tss_pkg::OP_UPDATE, 32'd5000, 0, 0, 0, 0, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_RTC, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 0, 0, 0);
        add_row(tss_pkg::OP_USER, 32'd5100, 0, 0, 0, 0, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_RTC, tss_pkg::ACT_WRITE, tss_pkg::USR_FAILED, 0, 0, 0);
        add_row(tss_pkg::OP_USER, 32'd5200, 0, 0, 0, 1, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_RTC, tss_pkg::ACT_WRITE, tss_pkg::USR_OK, 0, 0, 0);
        // forced read fails, then succeeds
        add_row(tss_pkg::OP_UPDATE, 32'd6000, 0, 0, 0, 0, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_RTC, tss_pkg::ACT_READ, tss_pkg::USR_NONE, 0, 0, 1);
        add_row(tss_pkg::OP_UPDATE, 32'd7000, 0, 0, 1, 0, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_RTC, tss_pkg::ACT_READ, tss_pkg::USR_NONE, 0, 0, 0);
        // inside the update period
        add_row(tss_pkg::OP_UPDATE, 32'd7500, 1, 1, 1, 1, tss_pkg::ST_OK, 0,
                tss_pkg::MODE_RTC, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 0, 0, 0);
        add_row(tss_pkg::OP_UPDATE, 32'd8000, 1, 0, 1, 0, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_WAIT, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 0, 0, 0);
        add_row(tss_pkg::OP_UPDATE, 32'd9000, 1, 0, 1, 0, tss_pkg::ST_OK, 0,
                tss_pkg::MODE_WAIT, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 0, 0, 0);
        // network wait reaches the warning time exactly
        add_row(tss_pkg::OP_UPDATE, 32'd68000, 1, 0, 1, 0, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_WAIT, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 0, 1, 0);
        add_row(tss_pkg::OP_UPDATE, 32'd69000, 1, 1, 1, 0, tss_pkg::ST_OK, 0,
                tss_pkg::MODE_ACTIVE, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 0, 0, 0);
        add_row(tss_pkg::OP_USER, 32'd69100, 1, 1, 1, 1, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_ACTIVE, tss_pkg::ACT_NONE, tss_pkg::USR_ACTIVE, 0, 0, 0);
        add_row(tss_pkg::OP_UPDATE, 32'd70000, 1, 1, 1, 0, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_ACTIVE, tss_pkg::ACT_WRITE, tss_pkg::USR_NONE, 0, 0, 1);
        add_row(tss_pkg::OP_START, 32'd70500, 1, 1, 0, 0, tss_pkg::ST_LOST_PWR, 1,
                tss_pkg::MODE_ACTIVE, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 1, 0, 1);
        // good write sync recovers lost power
        add_row(tss_pkg::OP_UPDATE, 32'd70500, 1, 1, 0, 1, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_ACTIVE, tss_pkg::ACT_WRITE, tss_pkg::USR_NONE, 0, 0, 0);
        add_row(tss_pkg::OP_START, 32'd80000, 1, 1, 1, 1, tss_pkg::ST_LOST_PWR, 0,
                tss_pkg::MODE_ACTIVE, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 1, 0, 0);
        add_row(tss_pkg::OP_UPDATE, 32'd80000, 0, 0, 1, 1, tss_pkg::ST_OK, 0,
                tss_pkg::MODE_RTC, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 1, 0, 0);
        // a user write leaves lost power set
        add_row(tss_pkg::OP_USER, 32'd80100, 0, 0, 1, 1, tss_pkg::ST_OK, 1,
                tss_pkg::MODE_RTC, tss_pkg::ACT_WRITE, tss_pkg::USR_OK, 1, 0, 0);
        add_row(tss_pkg::OP_UPDATE, 32'd81000, 0, 0, 1, 1, tss_pkg::ST_OK, 0,
                tss_pkg::MODE_RTC, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 1, 0, 0);
        add_row(tss_pkg::OP_UPDATE, 32'd82000, 1, 0, 0, 0, tss_pkg::ST_OK, 0,
                tss_pkg::MODE_WAIT, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 1, 0, 0);
        add_row(tss_pkg::OP_UPDATE, 32'd83000, 1, 1, 0, 0, tss_pkg::ST_OK, 0,
                tss_pkg::MODE_ACTIVE, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 1, 0, 0);
        add_row(tss_pkg::OP_UPDATE, 32'hFFFF_FFFF, 1, 1, 0, 1, tss_pkg::ST_OK, 0,
                tss_pkg::MODE_ACTIVE, tss_pkg::ACT_WRITE, tss_pkg::USR_NONE, 0, 0, 0);
        // tick wraps past zero
        add_row(tss_pkg::OP_UPDATE, 32'd999, 1, 1, 1, 0, tss_pkg::ST_OK, 0,
                tss_pkg::MODE_ACTIVE, tss_pkg::ACT_NONE, tss_pkg::USR_NONE, 0, 0, 0);

        wait (aresetn === 1'b1);

        foreach (plan[i]) begin
            row = plan[i];
            if ($urandom_range(0, 4) == 0) pause($urandom_range(1, 12));
            send(row.it, row.typed, row.res);
        end

        tick = $urandom;
        for (p = 0; p < 8; p++) begin
            settle();
            case (p)
                0: apply_settings('0, '0, '0, 8'd255);
                1: apply_settings(32'd1000, 32'd5000, 32'd3000, 8'd3);
                2: apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
                7: apply_settings($urandom_range(0, 500), $urandom_range(0, 5000),
                                  $urandom_range(0, 5000), 8'd1);
                default: apply_settings($urandom_range(1, 2000), $urandom_range(0, 20000),
                                        $urandom_range(0, 10000),
                                        8'($urandom_range(2, 255)));
            endcase
            // last phase may fault and runs without idling
            calm = (p == 7);
            count = (p == 2) ? 60 : (p == 7) ? 150 : 115;
            for (k = 0; k < count; k++) begin
                if (!calm && $urandom_range(0, 4) == 0) pause($urandom_range(1, 12));
                it = make_item(p == 7);
                send(it, 1'b0, '0);
            end
        end

        settle();
        repeat (4) @(posedge aclk);

        $display("%0d items sent, %0d results checked, %0d register writes in %0d settings",
                 n_items, n_results, n_cfg, n_settings);
        $display("results by state: rtc %0d wait %0d active %0d fault %0d, %0d warnings",
                 state_hits[tss_pkg::MODE_RTC], state_hits[tss_pkg::MODE_WAIT],
                 state_hits[tss_pkg::MODE_ACTIVE], state_hits[tss_pkg::MODE_FAULT],
                 n_warnings);
        if (n_mismatch == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> time_sync_supervisor.f
rtl/tss_pkg.sv
rtl/tss_cfg_regs.sv
rtl/tss_core.sv
rtl/time_sync_supervisor.sv
rtl/tss_checker.sv
tb/time_sync_supervisor_tb.sv
